[design/lsfb_pkg.sv]
package lsfb_pkg;

	localparam logic [1:0] CMD_SET   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_SHOW  = 2'd2;

	localparam logic [2:0] REG_NUM_LEDS       = 3'd0;
	localparam logic [2:0] REG_BRIGHTNESS     = 3'd1;
	localparam logic [2:0] REG_RED_POSITION   = 3'd2;
	localparam logic [2:0] REG_GREEN_POSITION = 3'd3;
	localparam logic [2:0] REG_BLUE_POSITION  = 3'd4;

	localparam logic [31:0] START_WORD = 32'h0000_0000;
	localparam logic [31:0] END_WORD   = 32'hFFFF_FFFF;
	localparam logic [7:0]  PIXEL_MARK = 8'hE3;

	localparam int APB_AW = 5;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] pixel_index;
		logic [23:0] color;
	} cmd_word_t;

	typedef struct packed {
		logic [31:0] frame_word;
		logic        last;
	} frame_word_t;

	// broadcast to every cell of the ring
	typedef struct packed {
		logic        clear;
		logic        set;
		logic        shift;
		logic [2:0]  bwe;
		logic [15:0] index;
		logic [23:0] wdata;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_ROT,
		ST_LAST
	} lsfb_state_t;

endpackage

[design/lsfb_cell.sv]
module lsfb_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsfb_pkg::cell_ctl_t  ctl,
	input  logic [23:0]          next_pixel,
	output logic [23:0]          pixel
);

	logic [23:0] pixel_q;
	logic        hit;

	assign hit   = ctl.set && (ctl.index == 16'(CELL_INDEX));
	assign pixel = pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_q <= '0;
		end else if (ctl.clear) begin
			pixel_q <= '0;
		end else if (ctl.shift) begin
			pixel_q <= next_pixel;
		end else if (hit) begin
			// byte 0 sits in the top bits
			for (int k = 0; k < 3; k++) begin
				if (ctl.bwe[k]) begin
					pixel_q[23 - 8 * k -: 8] <= ctl.wdata[23 - 8 * k -: 8];
				end
			end
		end
	end

endmodule

[design/led_strip_frame_builder_top.sv]
// LED strip frame builder. Commands arrive as words on the cmd channel: set writes one
// pixel's red, green and blue bytes at the byte positions held in the position registers
// (an index at or above num_leds is dropped), clear zeroes all pixels, show emits frame
// words on the frame channel: an all-zero start word, one word per LED in use (0xE3, then
// the three pixel bytes, optionally scaled by brightness/256), and an all-ones end word
// flagged with last. Pixels live in a ring of MAX_LEDS cells, one LED per cell; a show
// rotates the ring once around, and no new command is taken until its end word is
// loaded. Registers sit on an APB port at byte addresses 0, 4, 8, 12 and 16.
module led_strip_frame_builder_top #(
	parameter int MAX_LEDS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  lsfb_pkg::cmd_word_t           cmd_data,
	output logic                          frame_valid,
	input  logic                          frame_stall,
	output lsfb_pkg::frame_word_t         frame_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsfb_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int CW = $clog2(MAX_LEDS + 1);

	logic [4:0] num_leds_q;
	logic [7:0] brightness_q;
	logic [1:0] red_position_q;
	logic [1:0] green_position_q;
	logic [1:0] blue_position_q;

	lsfb_pkg::lsfb_state_t state_q, state_d;
	logic [CW-1:0]         rot_q;
	logic                  frame_valid_q;
	lsfb_pkg::frame_word_t frame_q;

	logic [6:0]            lim7;
	logic [CW-1:0]         count;
	logic                  cmd_acc;
	logic                  load_ok;
	logic                  emit;
	logic                  rot_wrap;
	logic                  load;
	lsfb_pkg::frame_word_t load_word;
	lsfb_pkg::cell_ctl_t   ctl;
	logic [23:0]           pix [MAX_LEDS];
	logic [23:0]           head_scaled;
	logic [2:0]            bwe;
	logic [23:0]           wdata;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_leds_q       <= 5'd24;
			brightness_q     <= 8'd0;
			red_position_q   <= 2'd2;
			green_position_q <= 2'd1;
			blue_position_q  <= 2'd0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				lsfb_pkg::REG_NUM_LEDS:       num_leds_q       <= pwdata[4:0];
				lsfb_pkg::REG_BRIGHTNESS:     brightness_q     <= pwdata[7:0];
				lsfb_pkg::REG_RED_POSITION:   red_position_q   <= pwdata[1:0];
				lsfb_pkg::REG_GREEN_POSITION: green_position_q <= pwdata[1:0];
				lsfb_pkg::REG_BLUE_POSITION:  blue_position_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			lsfb_pkg::REG_NUM_LEDS:       prdata = {27'd0, num_leds_q};
			lsfb_pkg::REG_BRIGHTNESS:     prdata = {24'd0, brightness_q};
			lsfb_pkg::REG_RED_POSITION:   prdata = {30'd0, red_position_q};
			lsfb_pkg::REG_GREEN_POSITION: prdata = {30'd0, green_position_q};
			lsfb_pkg::REG_BLUE_POSITION:  prdata = {30'd0, blue_position_q};
			default:                      prdata = '0;
		endcase
	end

	// LEDs in use, clamped to the ring size
	assign lim7  = ({2'd0, num_leds_q} > 7'(MAX_LEDS)) ? 7'(MAX_LEDS) : {2'd0, num_leds_q};
	assign count = CW'(lim7);

	assign cmd_stall   = (state_q != lsfb_pkg::ST_IDLE);
	assign cmd_acc     = cmd_valid && !cmd_stall;
	assign load_ok     = !frame_valid_q || !frame_stall;
	assign emit        = (rot_q < count);
	assign rot_wrap    = (rot_q == CW'(MAX_LEDS - 1));

	// pixel byte k takes the last color aimed at it: blue over green over red
	always_comb begin
		bwe   = '0;
		wdata = '0;
		for (int k = 0; k < 3; k++) begin
			bwe[k] = (red_position_q == 2'(k)) || (green_position_q == 2'(k))
				|| (blue_position_q == 2'(k));
			if (blue_position_q == 2'(k)) begin
				wdata[23 - 8 * k -: 8] = cmd_data.color[7:0];
			end else if (green_position_q == 2'(k)) begin
				wdata[23 - 8 * k -: 8] = cmd_data.color[15:8];
			end else begin
				wdata[23 - 8 * k -: 8] = cmd_data.color[23:16];
			end
		end
	end

	// brightness scaling of the head cell
	always_comb begin
		logic [15:0] prod;
		prod        = '0;
		head_scaled = pix[0];
		if (brightness_q != 8'd0) begin
			for (int k = 0; k < 3; k++) begin
				prod = {8'd0, pix[0][23 - 8 * k -: 8]} * {8'd0, brightness_q};
				head_scaled[23 - 8 * k -: 8] = prod[15:8];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lsfb_pkg::ST_IDLE: begin
				if (cmd_acc && cmd_data.cmd == lsfb_pkg::CMD_SHOW) begin
					state_d = lsfb_pkg::ST_START;
				end
			end
			lsfb_pkg::ST_START: begin
				if (load_ok) begin
					state_d = lsfb_pkg::ST_ROT;
				end
			end
			lsfb_pkg::ST_ROT: begin
				if ((!emit || load_ok) && rot_wrap) begin
					state_d = lsfb_pkg::ST_LAST;
				end
			end
			lsfb_pkg::ST_LAST: begin
				if (load_ok) begin
					state_d = lsfb_pkg::ST_IDLE;
				end
			end
			default: state_d = lsfb_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		load      = 1'b0;
		load_word = '{frame_word: lsfb_pkg::START_WORD, last: 1'b0};
		ctl       = '0;
		ctl.index = cmd_data.pixel_index;
		ctl.bwe   = bwe;
		ctl.wdata = wdata;
		case (state_q)
			lsfb_pkg::ST_IDLE: begin
				ctl.clear = cmd_acc && (cmd_data.cmd == lsfb_pkg::CMD_CLEAR);
				ctl.set   = cmd_acc && (cmd_data.cmd == lsfb_pkg::CMD_SET)
					&& (cmd_data.pixel_index < 16'(count));
			end
			lsfb_pkg::ST_START: begin
				load = load_ok;
			end
			lsfb_pkg::ST_ROT: begin
				// cells past the LEDs in use still rotate, without a word
				ctl.shift = emit ? load_ok : 1'b1;
				load      = emit && load_ok;
				load_word = '{frame_word: {lsfb_pkg::PIXEL_MARK, head_scaled}, last: 1'b0};
			end
			lsfb_pkg::ST_LAST: begin
				load      = load_ok;
				load_word = '{frame_word: lsfb_pkg::END_WORD, last: 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsfb_pkg::ST_IDLE;
			rot_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.shift) begin
				rot_q <= rot_wrap ? '0 : rot_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (load) begin
			frame_valid_q <= 1'b1;
		end else if (!frame_stall) begin
			frame_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= load_word;
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame_data  = frame_q;

	// pixel ring: cell i takes cell i+1 on a shift, the last cell takes cell 0
	for (genvar i = 0; i < MAX_LEDS; i++) begin : g_cell
		localparam int NEXT = (i + 1) % MAX_LEDS;
		lsfb_cell #(
			.CELL_INDEX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.next_pixel(pix[NEXT]),
			.pixel     (pix[i])
		);
	end

endmodule
